[rtl/core/sfr_pkg.sv]
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared constants, codes, types and the NVM contents for the serial frame
// responder.
// ----------------------------------------------------------------------------
package sfr_pkg;

    // NVM image and payload limits.
    localparam int NVM_DEPTH   = 128;
    localparam int NVM_AW      = $clog2(NVM_DEPTH);
    localparam int MAX_PAYLOAD = 15;

    // Frame framing.
    localparam logic [7:0] START_BYTE = 8'h02;

    // Message ids.
    localparam logic [3:0] ID_VERSION = 4'h0;
    localparam logic [3:0] ID_TOUCH   = 4'h3;
    localparam logic [3:0] ID_EEPROM  = 4'h4;
    localparam logic [3:0] ID_BATTERY = 4'h9;
    localparam logic [3:0] ID_NVM     = 4'hB;

    // Input item kinds.
    localparam logic [1:0] MODE_HOST    = 2'd0;
    localparam logic [1:0] MODE_PRESS   = 2'd1;
    localparam logic [1:0] MODE_RELEASE = 2'd2;

    // Configuration register indexes.
    localparam logic REG_VERSION = 1'b0;
    localparam logic REG_BATTERY = 1'b1;

    // Reset values and fixed payloads.
    localparam logic [31:0] VERSION_RESET = 32'h312E_3737;
    localparam logic [31:0] BATTERY_RESET = 32'h0100_0F01;
    localparam logic [31:0] EEPROM_WORD   = 32'hFFFF_0000;

    // One response frame to be sent by the emitter.
    typedef struct packed {
        logic        valid;
        logic [3:0]  id;
        logic [3:0]  len;
        logic        is_nvm;
        logic [31:0] word;
        logic [15:0] offset;
    } launch_t;

    // Fixed NVM image; entries past the listed ones are zero.
    function automatic logic [7:0] nvm_rom_byte(input logic [NVM_AW-1:0] addr);
        logic [7:0] b;
        b = 8'h00;
        case (int'(addr))
            0:                  b = 8'hAA;
            5:                  b = 8'h01;
            10:                 b = 8'h43;
            11:                 b = 8'h45;
            12:                 b = 8'h52;
            13:                 b = 8'h46;
            32:                 b = 8'hBB;
            28, 29, 30, 31:     b = 8'h0F;
            49, 50, 51, 52:     b = 8'h0F;
            53, 54, 55, 56:     b = 8'hFF;
            57, 58, 59, 60:     b = 8'h0F;
            65, 66, 67, 68:     b = 8'h0F;
            73, 74, 75, 76:     b = 8'h0F;
            81, 82, 83, 84:     b = 8'h0F;
            default:            b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

[rtl/core/sfr_if.sv]
// ----------------------------------------------------------------------------
// sfr_if
// Channel interfaces of the serial frame responder: input items, output
// bytes and configuration writes.
// ----------------------------------------------------------------------------
interface sfr_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] rx_byte;
    logic [9:0] touch_x;
    logic [9:0] touch_y;

    modport source (output valid, mode, rx_byte, touch_x, touch_y, input ready);
    modport sink (input valid, mode, rx_byte, touch_x, touch_y, output ready);
endinterface

interface sfr_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       last_byte;

    modport source (output valid, tx_byte, last_byte, input ready);
    modport sink (input valid, tx_byte, last_byte, output ready);
endinterface

interface sfr_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/serial_frame_responder_top.sv]
// ----------------------------------------------------------------------------
// serial_frame_responder_top
// A request is registered as a frame descriptor; the emitter passes its fetch
// and push states before the first response beat. Throughput: 1 input beat
// per cycle while idle; a frame of N bytes (3 to 18) blocks input until sent,
// via a fetch and a push state per byte. Reset: control state clears at once;
// then the NVM image fills the RAM (NVM_DEPTH bytes); no input beat is taken.
// ----------------------------------------------------------------------------
module serial_frame_responder_top (
    input  logic         clk,
    input  logic         rst_n,
    sfr_item_if.sink     item,
    sfr_result_if.source result,
    sfr_cfg_if.sink      cfg
);

    logic [sfr_pkg::NVM_AW:0]   fill_cnt_reg, fill_cnt_next;
    logic                       fill_done;
    logic [sfr_pkg::NVM_AW-1:0] fill_addr;
    logic [sfr_pkg::NVM_AW-1:0] raddr;
    logic [7:0]                 rdata;
    logic                       emit_idle;
    sfr_pkg::launch_t           launch;

    // Image load sweep after reset.
    assign fill_done     = (fill_cnt_reg == (sfr_pkg::NVM_AW + 1)'(sfr_pkg::NVM_DEPTH));
    assign fill_addr     = fill_cnt_reg[sfr_pkg::NVM_AW-1:0];
    assign fill_cnt_next = fill_done ? fill_cnt_reg
                                     : (fill_cnt_reg + (sfr_pkg::NVM_AW + 1)'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_cnt_reg <= '0;
        end
        else
        begin
            fill_cnt_reg <= fill_cnt_next;
        end
    end

    // Input beats are taken only when no frame is pending or being sent.
    assign item.ready = fill_done && emit_idle && !launch.valid;

    sfr_ram #(
        .WIDTH (8),
        .DEPTH (sfr_pkg::NVM_DEPTH)
    ) u_nvm_ram (
        .clk   (clk),
        .we    (!fill_done),
        .waddr (fill_addr),
        .wdata (sfr_pkg::nvm_rom_byte(fill_addr)),
        .raddr (raddr),
        .rdata (rdata)
    );

    sfr_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cfg    (cfg),
        .launch (launch)
    );

    sfr_emitter u_emitter (
        .clk    (clk),
        .rst_n  (rst_n),
        .launch (launch),
        .idle   (emit_idle),
        .raddr  (raddr),
        .rdata  (rdata),
        .result (result)
    );

endmodule

[rtl/core/sfr_ram.sv]
// ----------------------------------------------------------------------------
// sfr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/sfr_parser.sv]
// ----------------------------------------------------------------------------
// sfr_parser
// Host frame parser and configuration registers; turns completed requests
// and touch events into response frame descriptors.
// ----------------------------------------------------------------------------
module sfr_parser (
    input  logic               clk,
    input  logic               rst_n,
    sfr_item_if.sink           item,
    sfr_cfg_if.sink            cfg,
    output sfr_pkg::launch_t   launch
);

    typedef enum logic [3:0] {
        PH_WAIT  = 4'b0001,
        PH_HEAD  = 4'b0010,
        PH_DATA  = 4'b0100,
        PH_CKSUM = 4'b1000
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [3:0]       id_reg, id_next;
    logic [3:0]       len_reg, len_next;
    logic [4:0]       rcvd_reg, rcvd_next;
    logic [7:0]       rq_reg [3];
    logic [7:0]       rq_next [3];
    logic [31:0]      version_reg, version_next;
    logic [31:0]      battery_reg, battery_next;
    sfr_pkg::launch_t launch_reg, launch_next;

    logic             accept;
    logic [4:0]       rcvd_inc;
    logic [3:0]       nvm_cnt;
    logic [15:0]      nvm_off;

    assign accept    = item.valid && item.ready;
    assign cfg.ready = 1'b1;
    assign launch    = launch_reg;

    // Counted bytes saturate at 31.
    assign rcvd_inc = (rcvd_reg < 5'd31) ? (rcvd_reg + 5'd1) : rcvd_reg;

    // NVM request fields; bytes not received in this frame read as zero.
    assign nvm_off = {(rcvd_reg > 5'd1) ? rq_reg[1] : 8'h00,
                      (rcvd_reg > 5'd0) ? rq_reg[0] : 8'h00};
    always_comb
    begin
        if (rcvd_reg <= 5'd2)
        begin
            nvm_cnt = 4'd0;
        end
        else if (rq_reg[2] > 8'(sfr_pkg::MAX_PAYLOAD))
        begin
            nvm_cnt = 4'(sfr_pkg::MAX_PAYLOAD);
        end
        else
        begin
            nvm_cnt = rq_reg[2][3:0];
        end
    end

    // Configuration writes.
    always_comb
    begin
        version_next = version_reg;
        battery_next = battery_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                sfr_pkg::REG_VERSION: version_next = cfg.data;
                sfr_pkg::REG_BATTERY: battery_next = cfg.data;
            endcase
        end
    end

    // Parse state and frame launch.
    always_comb
    begin
        phase_next  = phase_reg;
        id_next     = id_reg;
        len_next    = len_reg;
        rcvd_next   = rcvd_reg;
        rq_next     = rq_reg;
        launch_next = '0;
        if (accept)
        begin
            unique case (item.mode)
                sfr_pkg::MODE_PRESS:
                begin
                    launch_next.valid = 1'b1;
                    launch_next.id    = sfr_pkg::ID_TOUCH;
                    launch_next.len   = 4'd4;
                    launch_next.word  = {6'd0, item.touch_y, 6'd0, item.touch_x};
                end
                sfr_pkg::MODE_RELEASE:
                begin
                    launch_next.valid = 1'b1;
                    launch_next.id    = sfr_pkg::ID_TOUCH;
                end
                sfr_pkg::MODE_HOST:
                begin
                    unique case (phase_reg)
                        PH_WAIT:
                        begin
                            if (item.rx_byte == sfr_pkg::START_BYTE)
                            begin
                                phase_next = PH_HEAD;
                            end
                        end
                        PH_HEAD:
                        begin
                            id_next    = item.rx_byte[7:4];
                            len_next   = item.rx_byte[3:0];
                            rcvd_next  = 5'd0;
                            phase_next = (item.rx_byte[3:0] == 4'd0) ? PH_CKSUM : PH_DATA;
                        end
                        PH_DATA:
                        begin
                            if (rcvd_reg < 5'd3)
                            begin
                                rq_next[rcvd_reg[1:0]] = item.rx_byte;
                            end
                            rcvd_next = rcvd_inc;
                            if (rcvd_inc >= {1'b0, len_reg})
                            begin
                                phase_next = PH_CKSUM;
                            end
                        end
                        PH_CKSUM:
                        begin
                            phase_next        = PH_WAIT;
                            launch_next.valid = 1'b1;
                            launch_next.id    = id_reg;
                            unique case (id_reg)
                                sfr_pkg::ID_VERSION:
                                begin
                                    launch_next.len  = 4'd4;
                                    launch_next.word = version_reg;
                                end
                                sfr_pkg::ID_EEPROM:
                                begin
                                    launch_next.len  = 4'd2;
                                    launch_next.word = sfr_pkg::EEPROM_WORD;
                                end
                                sfr_pkg::ID_BATTERY:
                                begin
                                    launch_next.len  = 4'd4;
                                    launch_next.word = battery_reg;
                                end
                                sfr_pkg::ID_NVM:
                                begin
                                    launch_next.len    = nvm_cnt;
                                    launch_next.is_nvm = 1'b1;
                                    launch_next.offset = nvm_off;
                                end
                                default:
                                begin
                                    launch_next.len = 4'd0;
                                end
                            endcase
                        end
                        default:
                        begin
                            phase_next = PH_WAIT;
                        end
                    endcase
                end
                default:
                begin
                    // The unused mode is dropped.
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_WAIT;
            id_reg      <= 4'd0;
            len_reg     <= 4'd0;
            rcvd_reg    <= 5'd0;
            rq_reg      <= '{default: 8'h00};
            version_reg <= sfr_pkg::VERSION_RESET;
            battery_reg <= sfr_pkg::BATTERY_RESET;
            launch_reg  <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            id_reg      <= id_next;
            len_reg     <= len_next;
            rcvd_reg    <= rcvd_next;
            rq_reg      <= rq_next;
            version_reg <= version_next;
            battery_reg <= battery_next;
            launch_reg  <= launch_next;
        end
    end

endmodule

[rtl/core/sfr_emitter.sv]
// ----------------------------------------------------------------------------
// sfr_emitter
// Response frame sequencer: sends start, header, payload and checksum beats,
// reading NVM payload bytes from the image RAM.
// ----------------------------------------------------------------------------
module sfr_emitter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sfr_pkg::launch_t            launch,
    output logic                        idle,
    output logic [sfr_pkg::NVM_AW-1:0]  raddr,
    input  logic [7:0]                  rdata,
    sfr_result_if.source                result
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_FETCH = 3'b010,
        ST_PUSH  = 3'b100
    } emit_state_t;

    emit_state_t state_reg, state_next;
    logic [3:0]  id_reg, id_next;
    logic [3:0]  len_reg, len_next;
    logic        nvm_reg, nvm_next;
    logic [31:0] word_reg, word_next;
    logic [16:0] addr_reg, addr_next;
    logic        inrange_reg, inrange_next;
    logic [4:0]  pos_reg, pos_next;
    logic [7:0]  cks_reg, cks_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        out_last_reg, out_last_next;

    logic        slot_free;
    logic [4:0]  last_pos;
    logic [7:0]  data_byte;

    assign slot_free = !out_valid_reg || result.ready;
    assign last_pos  = {1'b0, len_reg} + 5'd2;
    assign idle      = (state_reg == ST_IDLE);
    assign raddr     = addr_reg[sfr_pkg::NVM_AW-1:0];

    assign result.valid     = out_valid_reg;
    assign result.tx_byte   = out_byte_reg;
    assign result.last_byte = out_last_reg;

    // Payload byte: for NVM frames the image byte within range, else zero; otherwise the next word byte.
    assign data_byte = nvm_reg ? (inrange_reg ? rdata : 8'h00) : word_reg[31:24];

    // Sequencer: a fetch state then a push state per beat; the push waits for a free output slot.
    always_comb
    begin
        state_next     = state_reg;
        id_next        = id_reg;
        len_next       = len_reg;
        nvm_next       = nvm_reg;
        word_next      = word_reg;
        addr_next      = addr_reg;
        inrange_next   = inrange_reg;
        pos_next       = pos_reg;
        cks_next       = cks_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (launch.valid)
                begin
                    id_next    = launch.id;
                    len_next   = launch.len;
                    nvm_next   = launch.is_nvm;
                    word_next  = launch.word;
                    addr_next  = {1'b0, launch.offset};
                    pos_next   = 5'd0;
                    cks_next   = {launch.id, launch.len};
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                inrange_next = (addr_reg < 17'(sfr_pkg::NVM_DEPTH));
                state_next   = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b0;
                    pos_next       = pos_reg + 5'd1;
                    state_next     = ST_FETCH;
                    if (pos_reg == 5'd0)
                    begin
                        out_byte_next = sfr_pkg::START_BYTE;
                    end
                    else if (pos_reg == 5'd1)
                    begin
                        out_byte_next = {id_reg, len_reg};
                    end
                    else if (pos_reg == last_pos)
                    begin
                        out_byte_next = cks_reg;
                        out_last_next = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        out_byte_next = data_byte;
                        cks_next      = cks_reg + data_byte;
                        word_next     = {word_reg[23:0], 8'h00};
                        addr_next     = addr_reg + 17'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and output registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            id_reg        <= 4'd0;
            len_reg       <= 4'd0;
            nvm_reg       <= 1'b0;
            word_reg      <= 32'd0;
            addr_reg      <= 17'd0;
            inrange_reg   <= 1'b0;
            pos_reg       <= 5'd0;
            cks_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= 8'd0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            id_reg        <= id_next;
            len_reg       <= len_next;
            nvm_reg       <= nvm_next;
            word_reg      <= word_next;
            addr_reg      <= addr_next;
            inrange_reg   <= inrange_next;
            pos_reg       <= pos_next;
            cks_reg       <= cks_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            out_last_reg  <= out_last_next;
        end
    end

`ifndef NO_ASSERTIONS
    // A new frame is only handed over while no frame is in flight.
    a_launch_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        launch.valid |-> state_reg == ST_IDLE)
        else $error("frame launched while emitter busy");

    // The beat position never runs past the checksum beat.
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> pos_reg <= last_pos)
        else $error("beat position past end of frame");

    // Pushing the checksum beat ends the frame and marks it last.
    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUSH && slot_free && pos_reg == last_pos)
        |=> (state_reg == ST_IDLE && result.valid && result.last_byte))
        else $error("checksum beat did not close the frame");
`endif

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the serial frame responder. A short table of
// directed beats covers the request types, touch events and parser corner
// cases. It is followed by random host frames, touch events and noise under
// several register settings. Every response byte is compared against typed
// bytes or a behavioral predictor of the frame parser and response builder.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [1:0] MODE_UNUSED     = 2'd3;
    localparam int         NVM_USED        = 85;
    localparam int         SETTLE_CYCLES   = 40;
    localparam int         HOLD_OFF_CYCLES = 300;
    localparam int         STALL_LIMIT     = 2000;
    localparam int         PHASE_ITEMS     = 75;

    // Parser phases of the host frame receiver.
    typedef enum logic [3:0] {
        RX_IDLE     = 4'b0001,
        RX_HEADER   = 4'b0010,
        RX_PAYLOAD  = 4'b0100,
        RX_CHECKSUM = 4'b1000
    } rx_phase_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] rx_byte;
        logic [9:0] touch_x;
        logic [9:0] touch_y;
    } item_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_byte;
    } beat_t;

    // A directed row: the input beat and, where it is obvious, the frame it
    // must produce (left-justified bytes, n_typed of them).
    typedef struct {
        item_t       item;
        int          n_typed;
        logic [55:0] typed;
    } directed_row_t;

    localparam logic [7:0] NVM_IMAGE [0:NVM_USED-1] = '{
        'hAA, 'h00, 'h00, 'h00, 'h00, 'h01, 'h00, 'h00,
        'h00, 'h00, 'h43, 'h45, 'h52, 'h46, 'h00, 'h00,
        'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
        'h00, 'h00, 'h00, 'h00, 'h0F, 'h0F, 'h0F, 'h0F,
        'hBB, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
        'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00, 'h00,
        'h00, 'h0F, 'h0F, 'h0F, 'h0F, 'hFF, 'hFF, 'hFF,
        'hFF, 'h0F, 'h0F, 'h0F, 'h0F, 'h00, 'h00, 'h00,
        'h00, 'h0F, 'h0F, 'h0F, 'h0F, 'h00, 'h00, 'h00,
        'h00, 'h0F, 'h0F, 'h0F, 'h0F, 'h00, 'h00, 'h00,
        'h00, 'h0F, 'h0F, 'h0F, 'h0F
    };

    directed_row_t directed_table [25] = '{
        // A byte before any start byte is dropped.
        '{'{sfr_pkg::MODE_HOST, 8'h55, 10'd0, 10'd0}, 0, 56'h0},
        // Version request with reset register value.
        '{'{sfr_pkg::MODE_HOST, sfr_pkg::START_BYTE, 10'd0, 10'd0}, 0, 56'h0},
        '{'{sfr_pkg::MODE_HOST, 8'h00, 10'd0, 10'd0}, 0, 56'h0},
        '{'{sfr_pkg::MODE_HOST, 8'hFF, 10'd0, 10'd0}, 7, 56'h02_04_31_2E_37_37_D1},
        // EEPROM read.
        '{'{sfr_pkg::MODE_HOST, sfr_pkg::START_BYTE, 10'd0, 10'd0}, 0, 56'h0},
        '{'{sfr_pkg::MODE_HOST, 8'h40, 10'd0, 10'd0}, 0, 56'h0},
        '{'{sfr_pkg::MODE_HOST, 8'h00, 10'd0, 10'd0}, 5, 56'h02_42_FF_FF_40_00_00},
        // Battery request with reset register value.
        '{'{sfr_pkg::MODE_HOST, sfr_pkg::START_BYTE, 10'd0, 10'd0}, 0, 56'h0},
        '{'{sfr_pkg::MODE_HOST, 8'h90, 10'd0, 10'd0}, 0, 56'h0},
        '{'{sfr_pkg::MODE_HOST, 8'hAB, 10'd0, 10'd0}, 7, 56'h02_94_01_00_0F_01_A5},
        // Touch press at opposite corners, then a release.
        '{'{sfr_pkg::MODE_PRESS, 8'h00, 10'h3FF, 10'h000}, 7, 56'h02_34_00_00_03_FF_36},
        '{'{sfr_pkg::MODE_PRESS, 8'hFF, 10'h000, 10'h3FF}, 7, 56'h02_34_03_FF_00_00_36},
        '{'{sfr_pkg::MODE_RELEASE, 8'h00, 10'h3FF, 10'h3FF}, 3, 56'h02_30_30_00_00_00_00},
        // The unused mode is ignored entirely.
        '{'{MODE_UNUSED, 8'hFF, 10'h3FF, 10'h3FF}, 0, 56'h0},
        // Long NVM request: the fourth payload byte is dropped, the count clamps
        // and the read runs past the end of the image.
        '{'{sfr_pkg::MODE_HOST, sfr_pkg::START_BYTE, 10'd0, 10'd0}, 0, 56'h0},
        '{'{sfr_pkg::MODE_HOST, 8'hB4, 10'd0, 10'd0}, 0, 56'h0},
        '{'{sfr_pkg::MODE_HOST, 8'h50, 10'd0, 10'd0}, 0, 56'h0},
        '{'{sfr_pkg::MODE_HOST, 8'h00, 10'd0, 10'd0}, 0, 56'h0},
        '{'{sfr_pkg::MODE_HOST, 8'hFF, 10'd0, 10'd0}, 0, 56'h0},
        '{'{sfr_pkg::MODE_HOST, 8'h99, 10'd0, 10'd0}, 0, 56'h0},
        '{'{sfr_pkg::MODE_HOST, 8'h5A, 10'd0, 10'd0}, 0, 56'h0},
        // Short NVM request: missing count reads as zero, so the frame is empty.
        '{'{sfr_pkg::MODE_HOST, sfr_pkg::START_BYTE, 10'd0, 10'd0}, 0, 56'h0},
        '{'{sfr_pkg::MODE_HOST, 8'hB1, 10'd0, 10'd0}, 0, 56'h0},
        '{'{sfr_pkg::MODE_HOST, 8'h7F, 10'd0, 10'd0}, 0, 56'h0},
        '{'{sfr_pkg::MODE_HOST, 8'h00, 10'd0, 10'd0}, 3, 56'h02_B0_B0_00_00_00_00}
    };

    logic clk = 1'b0;
    logic rst_n;

    sfr_item_if   item_ch ();
    sfr_result_if res_ch ();
    sfr_cfg_if    cfg_ch ();

    serial_frame_responder_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    // Predictor state.
    rx_phase_t   rx_phase;
    logic [3:0]  req_id;
    logic [3:0]  req_len;
    int          req_count;
    logic [7:0]  req_data [3];
    logic [31:0] version_reg;
    logic [31:0] battery_reg;

    beat_t expected_tx [$];

    int  mismatch_count = 0;
    int  accepted_items = 0;
    int  ignored_items  = 0;
    int  frames_seen    = 0;
    int  bytes_seen     = 0;
    int  reg_writes     = 0;
    int  burst_left     = 0;
    int  idle_cycles    = 0;
    bit  hold_off_req   = 1'b0;
    bit  hold_off_used  = 1'b0;

    // Clock.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Append one complete frame: start, header, payload, checksum.
    function automatic void build_frame(input logic [3:0] id, input logic [7:0] data [15],
                                        input int len, ref beat_t beats [$]);
        logic [7:0] header;
        logic [7:0] sum;
        header = {id, len[3:0]};
        sum = header;
        beats.push_back('{sfr_pkg::START_BYTE, 1'b0});
        beats.push_back('{header, 1'b0});
        for (int i = 0; i < len; i++)
        begin
            beats.push_back('{data[i], 1'b0});
            sum += data[i];
        end
        beats.push_back('{sum, 1'b1});
    endfunction

    // Response to a completed host frame.
    function automatic void build_response(ref beat_t beats [$]);
        logic [7:0] data [15];
        int         off;
        int         cnt;
        int         addr;
        foreach (data[i])
            data[i] = 8'h00;
        case (req_id)
            sfr_pkg::ID_VERSION:
            begin
                {data[0], data[1], data[2], data[3]} = version_reg;
                build_frame(sfr_pkg::ID_VERSION, data, 4, beats);
            end
            sfr_pkg::ID_EEPROM:
            begin
                data[0] = 8'hFF;
                data[1] = 8'hFF;
                build_frame(sfr_pkg::ID_EEPROM, data, 2, beats);
            end
            sfr_pkg::ID_BATTERY:
            begin
                {data[0], data[1], data[2], data[3]} = battery_reg;
                build_frame(sfr_pkg::ID_BATTERY, data, 4, beats);
            end
            sfr_pkg::ID_NVM:
            begin
                // Request bytes not received in this frame count as zero.
                off = (req_count > 0) ? int'(req_data[0]) : 0;
                if (req_count > 1)
                    off += int'(req_data[1]) << 8;
                cnt = (req_count > 2) ? int'(req_data[2]) : 0;
                if (cnt > sfr_pkg::MAX_PAYLOAD)
                    cnt = sfr_pkg::MAX_PAYLOAD;
                for (int i = 0; i < cnt; i++)
                begin
                    addr = off + i;
                    data[i] = (addr < sfr_pkg::NVM_DEPTH && addr < NVM_USED)
                              ? NVM_IMAGE[addr] : 8'h00;
                end
                build_frame(sfr_pkg::ID_NVM, data, cnt, beats);
            end
            default:
                build_frame(req_id, data, 0, beats);
        endcase
    endfunction

    // Advance the predictor by one accepted beat and collect its response bytes.
    function automatic void predict_response(input item_t it, ref beat_t beats [$]);
        logic [7:0] data [15];
        foreach (data[i])
            data[i] = 8'h00;
        case (it.mode)
            sfr_pkg::MODE_PRESS:
            begin
                data[0] = {6'd0, it.touch_y[9:8]};
                data[1] = it.touch_y[7:0];
                data[2] = {6'd0, it.touch_x[9:8]};
                data[3] = it.touch_x[7:0];
                build_frame(sfr_pkg::ID_TOUCH, data, 4, beats);
            end
            sfr_pkg::MODE_RELEASE:
                build_frame(sfr_pkg::ID_TOUCH, data, 0, beats);
            sfr_pkg::MODE_HOST:
            begin
                case (rx_phase)
                    RX_IDLE:
                        if (it.rx_byte == sfr_pkg::START_BYTE)
                            rx_phase = RX_HEADER;
                    RX_HEADER:
                    begin
                        req_id = it.rx_byte[7:4];
                        req_len = it.rx_byte[3:0];
                        req_count = 0;
                        rx_phase = (req_len == 4'd0) ? RX_CHECKSUM : RX_PAYLOAD;
                    end
                    RX_PAYLOAD:
                    begin
                        // Only the first three payload bytes are kept.
                        if (req_count < 3)
                            req_data[req_count] = it.rx_byte;
                        if (req_count < 31)
                            req_count++;
                        if (req_count >= int'(req_len))
                            rx_phase = RX_CHECKSUM;
                    end
                    default:
                    begin
                        // The received checksum value is not checked.
                        rx_phase = RX_IDLE;
                        build_response(beats);
                    end
                endcase
            end
            default:
                ;
        endcase
    endfunction

    // Offer one input beat with bursty pacing and record what it must produce.
    task automatic send_item(input item_t it, input int n_typed, input logic [55:0] typed);
        beat_t beats [$];
        int    gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        item_ch.valid   <= 1'b1;
        item_ch.mode    <= it.mode;
        item_ch.rx_byte <= it.rx_byte;
        item_ch.touch_x <= it.touch_x;
        item_ch.touch_y <= it.touch_y;
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
        predict_response(it, beats);
        if (n_typed > 0)
        begin
            for (int k = 0; k < n_typed; k++)
                expected_tx.push_back('{typed[55 - 8 * k -: 8], k == n_typed - 1});
        end
        else
        begin
            foreach (beats[k])
                expected_tx.push_back(beats[k]);
        end
        if (it.mode == MODE_UNUSED)
            ignored_items++;
        else
            accepted_items++;
        burst_left--;
        @(negedge clk);
    endtask

    task automatic send_host(input logic [7:0] b);
        send_item('{sfr_pkg::MODE_HOST, b, 10'($urandom), 10'($urandom)}, 0, 56'h0);
    endtask

    task automatic send_touch();
        logic [1:0] kind;
        kind = ($urandom_range(0, 2) != 0) ? sfr_pkg::MODE_PRESS : sfr_pkg::MODE_RELEASE;
        send_item('{kind, 8'($urandom), 10'($urandom), 10'($urandom)}, 0, 56'h0);
    endtask

    // Drop the input valid and wait until the block has drained its output.
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        burst_left = 0;
        while (expected_tx.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [31:0] value);
        wait_idle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        if (idx == sfr_pkg::REG_VERSION)
            version_reg = value;
        else
            battery_reg = value;
        reg_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // One random episode: mostly well-formed request frames with random
    // content, the rest touch events, stray bytes, ignored beats and
    // truncated frames.
    task automatic random_episode();
        int         pick;
        int         id_pick;
        logic [3:0] id;
        logic [3:0] len;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            // Finish whatever frame noise left open.
            while (rx_phase != RX_IDLE)
                send_host(8'($urandom));
            id_pick = $urandom_range(0, 9);
            case (id_pick)
                0, 1, 2, 3: id = sfr_pkg::ID_NVM;
                4:          id = sfr_pkg::ID_VERSION;
                5:          id = sfr_pkg::ID_EEPROM;
                6:          id = sfr_pkg::ID_BATTERY;
                default:    id = 4'($urandom);
            endcase
            if (id == sfr_pkg::ID_NVM && $urandom_range(0, 3) != 0)
                len = 4'd3;
            else if ($urandom_range(0, 1) == 0)
                len = 4'd0;
            else
                len = 4'($urandom);
            send_host(sfr_pkg::START_BYTE);
            send_host({id, len});
            for (int i = 0; i < len; i++)
            begin
                // Touch events may land in the middle of a host frame.
                if ($urandom_range(0, 9) == 0)
                    send_touch();
                if (i == 0)
                    b = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 90)) : 8'($urandom);
                else if (i == 1)
                    b = ($urandom_range(0, 3) != 0) ? 8'h00 : 8'($urandom);
                else if (i == 2)
                    b = ($urandom_range(0, 1) != 0)
                        ? 8'($urandom_range(0, sfr_pkg::MAX_PAYLOAD + 1))
                        : 8'($urandom);
                else
                    b = 8'($urandom);
                send_host(b);
            end
            send_host(8'($urandom));
        end
        else if (pick < 82)
            send_touch();
        else if (pick < 90)
            repeat ($urandom_range(1, 3)) send_host(8'($urandom));
        else if (pick < 94)
            send_item('{MODE_UNUSED, 8'($urandom), 10'($urandom), 10'($urandom)}, 0, 56'h0);
        else
        begin
            // Truncated frame: the payload stops short of its length.
            len = 4'($urandom_range(2, 15));
            send_host(sfr_pkg::START_BYTE);
            send_host({4'($urandom), len});
            repeat ($urandom_range(0, len - 1)) send_host(8'($urandom));
        end
    endtask

    task automatic random_phase(input bit with_hold_off);
        int base;
        base = accepted_items;
        while (accepted_items - base < PHASE_ITEMS)
        begin
            if (with_hold_off && !hold_off_used && accepted_items - base >= 20)
            begin
                hold_off_req = 1'b1;
                hold_off_used = 1'b1;
            end
            random_episode();
        end
    endtask

    // Receiver pacing: changing stall styles, plus one long hold-off on request.
    initial
    begin : sink_pacing
        int style;
        int cyc;
        style = 0;
        cyc = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                if (cyc % 64 == 0)
                    style = $urandom_range(0, 3);
                case (style)
                    0:       res_ch.ready <= 1'b1;
                    1:       res_ch.ready <= 1'($urandom_range(0, 1));
                    2:       res_ch.ready <= (cyc % 4 != 0);
                    default: res_ch.ready <= ($urandom_range(0, 9) == 0);
                endcase
                cyc++;
            end
        end
    end

    // Compare every accepted response beat with the oldest expected one.
    always @(posedge clk)
    begin : tx_check
        beat_t want;
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            bytes_seen++;
            if (res_ch.last_byte === 1'b1)
                frames_seen++;
            if (expected_tx.size() == 0)
            begin
                $error("unexpected beat: tx_byte %02h last_byte %0b",
                       res_ch.tx_byte, res_ch.last_byte);
                mismatch_count++;
            end
            else
            begin
                want = expected_tx.pop_front();
                if (res_ch.tx_byte !== want.tx_byte)
                begin
                    $error("tx_byte: expected %02h, actual %02h", want.tx_byte, res_ch.tx_byte);
                    mismatch_count++;
                end
                if (res_ch.last_byte !== want.last_byte)
                begin
                    $error("last_byte: expected %0b, actual %0b",
                           want.last_byte, res_ch.last_byte);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: too many cycles without any beat on any channel.
    always @(posedge clk)
    begin
        if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
            (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) ||
            (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Main sequence.
    initial
    begin : main_sequence
        rst_n = 1'b0;
        item_ch.valid   <= 1'b0;
        item_ch.mode    <= sfr_pkg::MODE_HOST;
        item_ch.rx_byte <= 8'h00;
        item_ch.touch_x <= 10'd0;
        item_ch.touch_y <= 10'd0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= sfr_pkg::REG_VERSION;
        cfg_ch.data     <= 32'd0;

        rx_phase    = RX_IDLE;
        req_id      = 4'd0;
        req_len     = 4'd0;
        req_count   = 0;
        foreach (req_data[i])
            req_data[i] = 8'h00;
        version_reg = sfr_pkg::VERSION_RESET;
        battery_reg = sfr_pkg::BATTERY_RESET;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table, with the register reset values.
        foreach (directed_table[i])
            send_item(directed_table[i].item, directed_table[i].n_typed,
                      directed_table[i].typed);

        // Random traffic under extreme and random register settings.
        write_register(sfr_pkg::REG_VERSION, 32'h0000_0000);
        write_register(sfr_pkg::REG_BATTERY, 32'hFFFF_FFFF);
        random_phase(1'b1);
        write_register(sfr_pkg::REG_VERSION, 32'hFFFF_FFFF);
        write_register(sfr_pkg::REG_BATTERY, 32'h0000_0000);
        random_phase(1'b0);
        write_register(sfr_pkg::REG_VERSION, $urandom);
        write_register(sfr_pkg::REG_BATTERY, $urandom);
        random_phase(1'b0);

        wait_idle();

        $display("Run covered %0d input beats (%0d in the unused mode) and %0d register writes.",
                 accepted_items + ignored_items, ignored_items, reg_writes);
        $display("Checked %0d response frames, %0d bytes, %0d mismatches.",
                 frames_seen, bytes_seen, mismatch_count);
        if (mismatch_count == 0 && expected_tx.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
